// ===== src/ismc_pkg.sv =====
// ----------------------------------------------------------------------------
// ismc_pkg
// Shared types and constants of the interval span match counter.
// ----------------------------------------------------------------------------
package ismc_pkg;

    localparam int TABLE_DEPTH = 1024;
    // power of two, divides the table depth
    localparam int NUM_CELLS   = 4;
    localparam int BANK_DEPTH  = (TABLE_DEPTH + NUM_CELLS - 1) / NUM_CELLS;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LANE_W = $clog2(NUM_CELLS);
    localparam int ROW_W  = IDX_W - LANE_W;
    localparam int REM_W  = $clog2(NUM_CELLS + 1);

    localparam int CHROM_W = 8;
    localparam int POS_W   = 31;
    localparam int CFG_W   = 20;
    localparam int TAG_W   = 16;
    localparam int MATCH_W = 11;

    localparam logic [MATCH_W-1:0] COUNT_MAX   = '1;
    localparam logic [CFG_W-1:0]   GAP_RESET   = 20'd150;
    localparam logic [CFG_W-1:0]   SUPP_RESET  = 20'd20;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic REG_MAX_GAP     = 1'b0;
    localparam logic REG_MIN_SUPPORT = 1'b1;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   end_pos;
    } entry_t;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   left;
        logic [POS_W-1:0]   right;
        logic [CFG_W-1:0]   gap;
    } query_t;

    typedef struct packed {
        logic               en;
        logic [LANE_W-1:0]  lane;
        logic [ROW_W-1:0]   row;
        entry_t             entry;
    } wr_t;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [ROW_W-1:0]   row;
        logic [REM_W-1:0]   rem;
        logic [REM_W-1:0]   part;
    } token_t;

endpackage

// ===== src/interval_span_match_counter.sv =====
// ----------------------------------------------------------------------------
// interval_span_match_counter
// Table of reference intervals with span-match counting of query records.
// ----------------------------------------------------------------------------
// A load transaction appends one interval (load_rejected when the table of
// 1024 is full) and goes straight to the finish state on acceptance. A query
// walks the stored intervals through a chain of 4 cells, each owning one
// bank with one read port, so 4 intervals are checked per cycle; a query
// skips the walk when support does not exceed min_support or the table is
// empty. One transaction is in work at a time; a finished result waits in
// the output register while the next transaction is taken.
module interval_span_match_counter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [2:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         opcode,
    input  logic [ismc_pkg::CHROM_W-1:0] chrom_id,
    input  logic [ismc_pkg::POS_W-1:0]   left_pos,
    input  logic [ismc_pkg::POS_W-1:0]   right_pos,
    input  logic [ismc_pkg::CFG_W-1:0]   support,
    input  logic [ismc_pkg::TAG_W-1:0]   query_tag,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [ismc_pkg::MATCH_W-1:0] match_count,
    output logic                         load_rejected,
    output logic [ismc_pkg::TAG_W-1:0]   result_tag
);

    logic [ismc_pkg::CFG_W-1:0] max_gap_reg;
    logic [ismc_pkg::CFG_W-1:0] min_support_reg;
    logic                       cfg_write;

    ismc_pkg::wr_t    wr;
    ismc_pkg::query_t query;
    ismc_pkg::token_t chain [ismc_pkg::NUM_CELLS + 1];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_gap_reg     <= ismc_pkg::GAP_RESET;
            min_support_reg <= ismc_pkg::SUPP_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                ismc_pkg::REG_MAX_GAP:     max_gap_reg     <= pwdata[ismc_pkg::CFG_W-1:0];
                ismc_pkg::REG_MIN_SUPPORT: min_support_reg <= pwdata[ismc_pkg::CFG_W-1:0];
                default:                   max_gap_reg     <= max_gap_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ismc_pkg::REG_MAX_GAP:     prdata = {{(32 - ismc_pkg::CFG_W){1'b0}}, max_gap_reg};
            ismc_pkg::REG_MIN_SUPPORT: prdata = {{(32 - ismc_pkg::CFG_W){1'b0}}, min_support_reg};
            default:                   prdata = '0;
        endcase
    end

    ismc_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .opcode        (opcode),
        .chrom_id      (chrom_id),
        .left_pos      (left_pos),
        .right_pos     (right_pos),
        .support       (support),
        .query_tag     (query_tag),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .match_count   (match_count),
        .load_rejected (load_rejected),
        .result_tag    (result_tag),
        .max_gap       (max_gap_reg),
        .min_support   (min_support_reg),
        .wr            (wr),
        .query         (query),
        .tok_issue     (chain[0]),
        .tok_done      (chain[ismc_pkg::NUM_CELLS])
    );

    for (genvar k = 0; k < ismc_pkg::NUM_CELLS; k++)
    begin : g_cell
        ismc_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (wr.en && (wr.lane == ismc_pkg::LANE_W'(k))),
            .wr_row   (wr.row),
            .wr_entry (wr.entry),
            .query    (query),
            .tok_in   (chain[k]),
            .tok_out  (chain[k+1])
        );
    end

endmodule

// ===== src/ismc_cell.sv =====
// ----------------------------------------------------------------------------
// ismc_cell
// One cell of the walk chain: a bank of stored intervals, a compare against
// the query and a partial match count handed to the next cell.
// ----------------------------------------------------------------------------
module ismc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [ismc_pkg::ROW_W-1:0] wr_row,
    input  ismc_pkg::entry_t    wr_entry,
    input  ismc_pkg::query_t    query,
    input  ismc_pkg::token_t    tok_in,
    output ismc_pkg::token_t    tok_out
);

    ismc_pkg::entry_t bank [ismc_pkg::BANK_DEPTH];
    ismc_pkg::entry_t rd_reg;
    ismc_pkg::token_t tok_a_reg;
    ismc_pkg::token_t tok_out_reg;
    ismc_pkg::token_t tok_out_next;

    logic [ismc_pkg::POS_W-1:0] start_diff;
    logic [ismc_pkg::POS_W-1:0] end_diff;
    logic                       lane_live;
    logic                       hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bank[wr_row] <= wr_entry;
        end
        rd_reg <= bank[tok_in.row];
    end

    always_comb
    begin
        start_diff = rd_reg.start_pos - query.left;
        end_diff   = query.right - rd_reg.end_pos;
        lane_live  = (tok_a_reg.rem != '0);
        hit = lane_live
            && (rd_reg.chrom == query.chrom)
            && (rd_reg.start_pos > query.left)
            && (start_diff < {{(ismc_pkg::POS_W - ismc_pkg::CFG_W){1'b0}}, query.gap})
            && (query.right > rd_reg.end_pos)
            && (end_diff < {{(ismc_pkg::POS_W - ismc_pkg::CFG_W){1'b0}}, query.gap});

        tok_out_next      = tok_a_reg;
        tok_out_next.part = tok_a_reg.part + {{(ismc_pkg::REM_W - 1){1'b0}}, hit};
        tok_out_next.rem  = lane_live ? tok_a_reg.rem - 1'b1 : tok_a_reg.rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg   <= '0;
            tok_out_reg <= '0;
        end
        else
        begin
            tok_a_reg   <= tok_in;
            tok_out_reg <= tok_out_next;
        end
    end

    assign tok_out = tok_out_reg;

endmodule

// ===== src/ismc_seq.sv =====
// ----------------------------------------------------------------------------
// ismc_seq
// Transaction control: table fill, walk issue into the cell chain, match
// accumulation and the result register.
// ----------------------------------------------------------------------------
module ismc_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         opcode,
    input  logic [ismc_pkg::CHROM_W-1:0] chrom_id,
    input  logic [ismc_pkg::POS_W-1:0]   left_pos,
    input  logic [ismc_pkg::POS_W-1:0]   right_pos,
    input  logic [ismc_pkg::CFG_W-1:0]   support,
    input  logic [ismc_pkg::TAG_W-1:0]   query_tag,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [ismc_pkg::MATCH_W-1:0] match_count,
    output logic                         load_rejected,
    output logic [ismc_pkg::TAG_W-1:0]   result_tag,
    input  logic [ismc_pkg::CFG_W-1:0]   max_gap,
    input  logic [ismc_pkg::CFG_W-1:0]   min_support,
    output ismc_pkg::wr_t                wr,
    output ismc_pkg::query_t             query,
    output ismc_pkg::token_t             tok_issue,
    input  ismc_pkg::token_t             tok_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t                          state_reg;
    logic [ismc_pkg::CNT_W-1:0]      count_reg;
    logic [ismc_pkg::CNT_W-1:0]      idx_reg;
    logic [ismc_pkg::MATCH_W-1:0]    acc_reg;
    logic                            rej_reg;
    logic [ismc_pkg::TAG_W-1:0]      tag_reg;
    logic [ismc_pkg::CHROM_W-1:0]    chrom_reg;
    logic [ismc_pkg::POS_W-1:0]      left_reg;
    logic [ismc_pkg::POS_W-1:0]      right_reg;
    logic                            result_valid_reg;
    logic [ismc_pkg::MATCH_W-1:0]    match_count_reg;
    logic                            load_rejected_reg;
    logic [ismc_pkg::TAG_W-1:0]      result_tag_reg;

    logic                            accept;
    logic                            table_full;
    logic                            slot_free;
    logic [ismc_pkg::CNT_W-1:0]      left_cnt;
    logic                            issue_last;
    logic [ismc_pkg::MATCH_W:0]      acc_sum;
    logic [ismc_pkg::MATCH_W-1:0]    acc_next;

    always_comb
    begin
        item_stall = (state_reg != S_IDLE);
        accept     = item_valid && !item_stall;
        table_full = !(count_reg < ismc_pkg::CNT_W'(ismc_pkg::TABLE_DEPTH));
        slot_free  = !result_valid_reg || !result_stall;

        wr.en          = accept && (opcode == ismc_pkg::OP_LOAD) && !table_full;
        wr.lane        = count_reg[ismc_pkg::LANE_W-1:0];
        wr.row         = count_reg[ismc_pkg::IDX_W-1:ismc_pkg::LANE_W];
        wr.entry.chrom     = chrom_id;
        wr.entry.start_pos = left_pos;
        wr.entry.end_pos   = right_pos;

        query.chrom = chrom_reg;
        query.left  = left_reg;
        query.right = right_reg;
        query.gap   = max_gap;

        left_cnt   = count_reg - idx_reg;
        issue_last = !(left_cnt > ismc_pkg::CNT_W'(ismc_pkg::NUM_CELLS));
        tok_issue.valid = (state_reg == S_WALK);
        tok_issue.last  = issue_last;
        tok_issue.row   = idx_reg[ismc_pkg::IDX_W-1:ismc_pkg::LANE_W];
        tok_issue.rem   = issue_last ? left_cnt[ismc_pkg::REM_W-1:0]
                                     : ismc_pkg::REM_W'(ismc_pkg::NUM_CELLS);
        tok_issue.part  = '0;

        acc_sum  = {1'b0, acc_reg}
                 + {{(ismc_pkg::MATCH_W + 1 - ismc_pkg::REM_W){1'b0}}, tok_done.part};
        acc_next = acc_sum[ismc_pkg::MATCH_W] ? ismc_pkg::COUNT_MAX
                                              : acc_sum[ismc_pkg::MATCH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            idx_reg           <= '0;
            acc_reg           <= '0;
            rej_reg           <= 1'b0;
            tag_reg           <= '0;
            chrom_reg         <= '0;
            left_reg          <= '0;
            right_reg         <= '0;
            result_valid_reg  <= 1'b0;
            match_count_reg   <= '0;
            load_rejected_reg <= 1'b0;
            result_tag_reg    <= '0;
        end
        else
        begin
            if (result_valid_reg && !result_stall && (state_reg != S_FINISH))
            begin
                result_valid_reg <= 1'b0;
            end
            if (tok_done.valid)
            begin
                acc_reg <= acc_next;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        tag_reg   <= query_tag;
                        chrom_reg <= chrom_id;
                        left_reg  <= left_pos;
                        right_reg <= right_pos;
                        acc_reg   <= '0;
                        idx_reg   <= '0;
                        rej_reg   <= (opcode == ismc_pkg::OP_LOAD) && table_full;
                        if (opcode == ismc_pkg::OP_LOAD)
                        begin
                            if (!table_full)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            state_reg <= S_FINISH;
                        end
                        else if ((support > min_support) && (count_reg != '0))
                        begin
                            state_reg <= S_WALK;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_WALK:
                begin
                    idx_reg <= idx_reg + ismc_pkg::CNT_W'(ismc_pkg::NUM_CELLS);
                    if (issue_last)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (tok_done.valid && tok_done.last)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (slot_free)
                    begin
                        match_count_reg   <= acc_reg;
                        load_rejected_reg <= rej_reg;
                        result_tag_reg    <= tag_reg;
                        result_valid_reg  <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid  = result_valid_reg;
    assign match_count   = match_count_reg;
    assign load_rejected = load_rejected_reg;
    assign result_tag    = result_tag_reg;

endmodule
